>>> rtl/core/fpns_pkg.sv
// Package for the fixed-point Newton square root core.
// Widths, configuration register indexes, reset values and the sequencer states.
// No dependencies.
`default_nettype none

package fpns_pkg;

    localparam int DATA_W         = 32;   // Q format word width
    localparam int FRAC_BITS_DEF  = 16;   // default fraction bits
    localparam int TOL_W          = 16;
    localparam int ITER_W         = 10;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITER  = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_RESET      = 16'd6;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 10'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } fpns_state_t;

endpackage

`default_nettype wire

>>> rtl/core/fpns_div.sv
// Bit-serial restoring divider: (num << FRAC_BITS) / den, low DATA_W quotient bits.
// One quotient bit per cycle; a zero divisor yields all ones. Uses fpns_pkg.
`default_nettype none

module fpns_div #(
    parameter int FRAC_BITS = fpns_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fpns_pkg::DATA_W-1:0] num,
    input  wire logic [fpns_pkg::DATA_W-1:0] den,
    output logic                             busy,
    output logic                             done,
    output logic [fpns_pkg::DATA_W-1:0]      quo
);

    localparam int DW    = fpns_pkg::DATA_W;
    localparam int NUM_W = DW + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;

    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;
    logic             ge;

    // one restoring step: bring down the next numerator bit, trial subtract
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            num_next  = {num, {FRAC_BITS{1'b0}}};
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/fixed_point_newton_sqrt.sv
// Top level of the fixed-point Newton square root core: stream ports, config
// registers, step sequencer and update datapath. Uses fpns_pkg and fpns_div.
//
//  Channel   Ports                                   Dir  Contents
//  --------  --------------------------------------  ---  ---------------------------------
//  input     s_tvalid, s_tready, s_tdata[31:0]       in   radicand, unsigned Q16.16
//  output    m_tvalid, m_tready, m_tdata, m_tuser    out  root (tdata), limit_hit (tuser)
//  config    cfg_we, cfg_addr, cfg_data[15:0]        in   0: tolerance, 1: max_iterations
//
//  Each Newton step runs the bit-serial divider over 32+FRAC_BITS quotient bits (FRAC_BITS is 16
//  at Q16.16), then takes the quotient, then compares; the compare state (or the accept, for the
//  first step) also loads the divider. A zero radicand or a zero step limit is answered in the
//  cycle after acceptance. Only one request is in flight; s_tready is low until the result
//  has been taken. A stalled result holds on m_tdata/m_tuser.
//  Reset (rst_n, asynchronous) sets tolerance to 6 and max_iterations to 1000.
`default_nettype none

module fixed_point_newton_sqrt #(
    parameter int FRAC_BITS = fpns_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fpns_pkg::DATA_W-1:0]     s_tdata,   // [31:0] radicand
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fpns_pkg::DATA_W-1:0]          m_tdata,   // [31:0] root
    output logic                                 m_tuser,   // [0] limit_hit
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [fpns_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fpns_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DW = fpns_pkg::DATA_W;
    localparam int TW = fpns_pkg::TOL_W;
    localparam int IW = fpns_pkg::ITER_W;

    fpns_pkg::fpns_state_t state_reg, state_next;

    logic [TW-1:0] tol_reg;
    logic [IW-1:0] max_iter_reg;

    logic [DW-1:0] b_reg, b_next;          // radicand held for the run
    logic [DW-1:0] guess_reg, guess_next;  // current estimate
    logic [DW-1:0] est_reg, est_next;      // candidate next estimate
    logic [IW-1:0] left_reg, left_next;    // steps remaining
    logic [DW-1:0] root_reg, root_next;
    logic          flag_reg, flag_next;

    logic          in_req;
    logic          trivial;
    logic          converged;
    logic [DW-1:0] sum;
    logic [DW-1:0] diff;

    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [DW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [DW-1:0] div_quo;

    assign in_req    = s_tvalid && s_tready;
    // zero radicand, or no step allowed: answer straight away
    assign trivial   = (s_tdata == '0) || (max_iter_reg == '0);
    assign sum       = guess_reg + div_quo;            // wraps at 32 bits
    assign diff      = guess_reg - est_reg;            // wrapped decrease
    assign converged = (diff < {{(DW-TW){1'b0}}, tol_reg});

    // shared divider: first step divides by the radicand itself
    assign div_num = (state_reg == fpns_pkg::ST_IDLE) ? s_tdata : b_reg;
    assign div_den = (state_reg == fpns_pkg::ST_IDLE) ? s_tdata : est_reg;

    fpns_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= fpns_pkg::TOL_RESET;
            max_iter_reg <= fpns_pkg::MAX_ITER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fpns_pkg::CFG_TOLERANCE: tol_reg      <= cfg_data[TW-1:0];
                fpns_pkg::CFG_MAX_ITER:  max_iter_reg <= cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpns_pkg::ST_IDLE:
            begin
                if (in_req)
                    state_next = trivial ? fpns_pkg::ST_OUT : fpns_pkg::ST_DIV;
            end
            fpns_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = fpns_pkg::ST_UPD;
            end
            fpns_pkg::ST_UPD:
            begin
                if (converged || (left_reg == IW'(1)))
                    state_next = fpns_pkg::ST_OUT;
                else
                    state_next = fpns_pkg::ST_DIV;
            end
            fpns_pkg::ST_OUT:
            begin
                if (m_tready)
                    state_next = fpns_pkg::ST_IDLE;
            end
            default: state_next = fpns_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            fpns_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && !trivial;
            end
            fpns_pkg::ST_UPD: div_start = !converged && (left_reg != IW'(1));
            fpns_pkg::ST_OUT: m_tvalid  = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        b_next     = b_reg;
        guess_next = guess_reg;
        est_next   = est_reg;
        left_next  = left_reg;
        root_next  = root_reg;
        flag_next  = flag_reg;
        case (state_reg)
            fpns_pkg::ST_IDLE:
            begin
                if (in_req)
                begin
                    b_next     = s_tdata;
                    guess_next = s_tdata;
                    left_next  = max_iter_reg;
                    // only used on the immediate answer: zero gives 0/0,
                    // a zero step limit gives the radicand with the flag
                    root_next  = s_tdata;
                    flag_next  = (s_tdata != '0);
                end
            end
            fpns_pkg::ST_DIV:
            begin
                if (div_done)
                    est_next = {1'b0, sum[DW-1:1]};
            end
            fpns_pkg::ST_UPD:
            begin
                root_next  = est_reg;
                flag_next  = !converged;
                guess_next = est_reg;
                left_next  = left_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpns_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        guess_reg <= guess_next;
        est_reg   <= est_next;
        left_reg  <= left_next;
        root_reg  <= root_next;
        flag_reg  <= flag_next;
    end

    assign m_tdata = root_reg;
    assign m_tuser = flag_reg;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_zero_in: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata == '0))
        |=> (m_tvalid && (m_tdata == '0) && !m_tuser))
        else $error("zero radicand did not give an immediate zero root");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpns_pkg::ST_UPD) |-> (left_reg != '0))
        else $error("step taken with no steps left");
`endif

endmodule

`default_nettype wire

>>> verif/tb_fixed_point_newton_sqrt.sv
// Self-checking testbench for fixed_point_newton_sqrt: stream requests in, roots out.
// Holds its own Newton predictor in a small scoreboard class; needs fpns_pkg and the core.
`timescale 1ns / 1ps

module tb_fixed_point_newton_sqrt;

    localparam int DATA_W     = fpns_pkg::DATA_W;
    localparam int TOL_W      = fpns_pkg::TOL_W;
    localparam int ITER_W     = fpns_pkg::ITER_W;
    localparam int CFG_ADDR_W = fpns_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = fpns_pkg::CFG_DATA_W;

    localparam int FRAC = fpns_pkg::FRAC_BITS_DEF;
    // one Newton step: 32+FRAC quotient bits, take quotient, compare (loads the next one)
    localparam int STEP_CYCLES = FRAC + 34;
    localparam int PHASE_REQUESTS = 63;

    typedef struct packed {
        logic              limit_hit;
        logic [DATA_W-1:0] root;
    } root_result_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    // Boundary radicands run with the reset settings. The top range makes the first
    // guess plus quotient wrap, which drives the guess to zero (all-ones quotient) or to a
    // small value that gives quotients wider than 32 bits.
    localparam logic [DATA_W-1:0] EDGE_RADICANDS [12] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_0000,
        32'hFFFF_0001, 32'h0001_0000, 32'h0004_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };

    // Expected roots in request order, plus a private copy of the two registers.
    class sqrt_scoreboard;
        logic [TOL_W-1:0]  tol;
        logic [ITER_W-1:0] max_steps;
        root_result_t      expected_q[$];
        int unsigned       mismatches;

        function new();
            tol        = fpns_pkg::TOL_RESET;
            max_steps  = fpns_pkg::MAX_ITER_RESET;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] val);
            if (idx == fpns_pkg::CFG_TOLERANCE)
                tol = val[TOL_W-1:0];
            else if (idx == fpns_pkg::CFG_MAX_ITER)
                max_steps = val[ITER_W-1:0];
        endfunction

        function root_result_t newton_root(logic [DATA_W-1:0] rad);
            logic [DATA_W-1:0]   guess;
            logic [DATA_W-1:0]   quot;
            logic [DATA_W-1:0]   sum;
            logic [DATA_W-1:0]   next_guess;
            logic [DATA_W-1:0]   drop;
            logic [2*DATA_W-1:0] wide;
            int unsigned         steps_left;
            root_result_t        res;
            res.root      = '0;
            res.limit_hit = 1'b0;
            if (rad == '0)
                return res;
            guess = rad;
            for (steps_left = max_steps; steps_left != 0; steps_left--)
            begin
                // divide by zero saturates, as the serial divider does
                if (guess == '0)
                    quot = '1;
                else
                begin
                    wide = {{DATA_W{1'b0}}, rad} << FRAC;
                    quot = DATA_W'(wide / {{DATA_W{1'b0}}, guess});
                end
                sum        = guess + quot;
                next_guess = sum >> 1;
                drop       = guess - next_guess;
                if (drop < {{(DATA_W-TOL_W){1'b0}}, tol})
                begin
                    res.root = next_guess;
                    return res;
                end
                guess = next_guess;
            end
            res.root      = guess;
            res.limit_hit = 1'b1;
            return res;
        endfunction

        function void note_request(logic [DATA_W-1:0] rad);
            expected_q.push_back(newton_root(rad));
        endfunction

        function void check_result(logic [DATA_W-1:0] root, logic limit_hit);
            root_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("root result %h with no request outstanding", root);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (root !== want.root)
            begin
                $error("root: expected %h, got %h", want.root, root);
                mismatches++;
            end
            if (limit_hit !== want.limit_hit)
            begin
                $error("limit_hit: expected %b, got %b", want.limit_hit, limit_hit);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;   // [31:0] radicand
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;         // [31:0] root
    logic                  m_tuser;         // [0] limit_hit
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sqrt_scoreboard sb = new();

    int    src_idle_pct   = 0;
    int    sink_stall_pct = 0;
    // cycle allowance, grown with every request offered; the watchdog fires well past it
    longint cycle_budget  = 50000;
    longint cycles        = 0;

    fixed_point_newton_sqrt #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sink back-pressure: one decision per cycle, changed on the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Both handshakes are sampled on the rising edge, pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 4 * cycle_budget)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic set_idle(idle_mode_t mode);
        src_idle_pct   = (mode == IDLE_SRC)  ? 54 : (mode == IDLE_BOTH) ? 19 : 0;
        sink_stall_pct = (mode == IDLE_SINK) ? 54 : (mode == IDLE_BOTH) ? 19 : 0;
    endtask

    // Called on a falling edge; returns on the falling edge after acceptance with
    // s_tvalid still high, so back-to-back requests never toggle it within a step.
    task automatic send_radicand(logic [DATA_W-1:0] rad);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        cycle_budget += 1 + ((sb.max_steps == 0) ? 1 : sb.max_steps) * STEP_CYCLES + 300;
        s_tvalid <= 1'b1;
        s_tdata  <= rad;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every outstanding root has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only ever called with the core idle. Both writes go back to back.
    task automatic set_config(logic [TOL_W-1:0] tol, logic [ITER_W-1:0] steps);
        cfg_we   <= 1'b1;
        cfg_addr <= fpns_pkg::CFG_TOLERANCE;
        cfg_data <= tol;
        @(negedge clk);
        sb.set_register(fpns_pkg::CFG_TOLERANCE, tol);
        cfg_addr <= fpns_pkg::CFG_MAX_ITER;
        cfg_data <= CFG_DATA_W'(steps);
        @(negedge clk);
        sb.set_register(fpns_pkg::CFG_MAX_ITER, CFG_DATA_W'(steps));
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] random_radicand();
        logic [15:0] r;
        r = 16'($urandom_range(65535));
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);   // spread over magnitudes
            2: return DATA_W'(r);                        // below 1.0, zero included
            3: return {16'hFFFF, r};                     // first step wraps
            4: return DATA_W'(r) * DATA_W'(r);           // exact squares
            default: return {8'h00, 8'($urandom_range(255)), 16'h0000};
        endcase
    endfunction

    initial
    begin
        idle_mode_t mode;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: boundary radicands under the reset settings
        set_idle(IDLE_NONE);
        foreach (EDGE_RADICANDS[i])
            send_radicand(EDGE_RADICANDS[i]);
        wait_drained();

        // zero tolerance with a single step: every nonzero radicand runs out
        set_config(16'd0, 10'd1);
        send_radicand(32'h0001_0000);
        send_radicand(32'hFFFF_FFFF);
        send_radicand(32'h0000_0000);
        wait_drained();

        // zero step limit: radicand comes back with limit set, zero still gives zero
        set_config(16'hFFFF, 10'd0);
        send_radicand(32'h0000_0000);
        send_radicand(32'h0000_0005);
        send_radicand(32'hFFFF_FFFF);
        wait_drained();

        // widest tolerance, longest limit
        set_config(16'hFFFF, 10'd1023);
        send_radicand(32'hFFFF_0000);
        send_radicand(32'h0009_0000);
        send_radicand(32'h0000_0002);
        wait_drained();

        // random phases; tolerance below two cannot end an oscillation, so keep
        // the step limit short there
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_config(fpns_pkg::TOL_RESET, fpns_pkg::MAX_ITER_RESET);
                1: set_config(16'hFFFF, 10'd1023);
                2: set_config(16'd0, ITER_W'($urandom_range(1, 40)));
                3: set_config(16'd1, ITER_W'($urandom_range(1, 60)));
                4: set_config(TOL_W'($urandom_range(2, 65535)),
                              ITER_W'($urandom_range(16, 1023)));
                default: set_config(TOL_W'($urandom_range(65535)),
                                    ITER_W'($urandom_range(12)));
            endcase
            mode = idle_mode_t'(p % 4);
            set_idle(mode);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                send_radicand(random_radicand());
                // hold the sender off once until the core has fully drained
                if (p == 1 && n == PHASE_REQUESTS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (50) @(negedge clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/fpns_pkg.sv
rtl/core/fpns_div.sv
rtl/core/fixed_point_newton_sqrt.sv
verif/tb_fixed_point_newton_sqrt.sv
